FILE: hw/rtl/crg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crg_pkg
// shared types and constants of the command record guard
// ----------------------------------------------------------------------------
package crg_pkg;

    localparam int unsigned ADDR_W   = 48;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned KEY_W    = 64;
    localparam int unsigned PROD_W   = 64;
    localparam int unsigned SCALED_W = 80;
    localparam int unsigned LIM16_W  = 16;
    localparam int unsigned LIM8_W   = 8;

    localparam logic [ADDR_W-1:0] REGION_SIZE_RST = 48'd0;
    localparam logic [WORD_W-1:0] GRID_LIMIT_RST  = 32'd1048576;

    // request types
    localparam logic [2:0] REQ_REGISTER = 3'd0;
    localparam logic [2:0] REQ_COPY     = 3'd1;
    localparam logic [2:0] REQ_FILL     = 3'd2;
    localparam logic [2:0] REQ_UPDATE   = 3'd3;
    localparam logic [2:0] REQ_DISPATCH = 3'd4;
    localparam logic [2:0] REQ_BIND     = 3'd5;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BOUNDS    = 3'd1;
    localparam logic [2:0] ST_BAD_FILL  = 3'd2;
    localparam logic [2:0] ST_NO_KERNEL = 3'd3;
    localparam logic [2:0] ST_BAD_DISP  = 3'd4;
    localparam logic [2:0] ST_BAD_GRID  = 3'd5;
    localparam logic [2:0] ST_FULL      = 3'd6;

    // configuration register indexes
    localparam logic REG_REGION_SIZE = 1'b0;
    localparam logic REG_GRID_LIMIT  = 1'b1;

    typedef struct packed {
        logic load;
        logic search;
        logic mul_a;
        logic mul_b;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic key_req;
        logic search_done;
    } t_sts;

endpackage
`default_nettype wire

FILE: hw/rtl/crg_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crg_ram
// generic simple dual port ram, one write port, registered read
// ----------------------------------------------------------------------------
module crg_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: hw/rtl/crg_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crg_dp
// datapath: input record, key table search, range and grid checks, result
// ----------------------------------------------------------------------------
module crg_dp import crg_pkg::*; #(
    parameter int unsigned KERNEL_SLOTS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    output t_sts                   o_sts,
    input  wire logic [ADDR_W-1:0] i_region_size,
    input  wire logic [WORD_W-1:0] i_grid_limit,
    input  wire logic [2:0]        i_req_type,
    input  wire logic [WORD_W-1:0] i_key_exec,
    input  wire logic [WORD_W-1:0] i_key_export,
    input  wire logic [ADDR_W-1:0] i_addr_src,
    input  wire logic [ADDR_W-1:0] i_addr_dst,
    input  wire logic [ADDR_W-1:0] i_byte_len,
    input  wire logic [WORD_W-1:0] i_aux_count,
    input  wire logic [WORD_W-1:0] i_grid_x,
    input  wire logic [WORD_W-1:0] i_grid_y,
    input  wire logic [WORD_W-1:0] i_grid_z,
    input  wire logic [WORD_W-1:0] i_group_size_z,
    input  wire logic [WORD_W-1:0] i_push_const_count,
    output logic      [2:0]        o_status,
    output logic      [3:0]        o_kernel_slot
);

    localparam int unsigned AW = (KERNEL_SLOTS > 1) ? $clog2(KERNEL_SLOTS) : 1;
    localparam int unsigned CW = $clog2(KERNEL_SLOTS + 1);
    localparam logic [CW-1:0] SLOTS = CW'(KERNEL_SLOTS);

    // captured item
    logic [2:0]        r_type;
    logic [KEY_W-1:0]  r_key;
    logic [ADDR_W-1:0] r_src;
    logic [ADDR_W-1:0] r_dst;
    logic [ADDR_W-1:0] r_len;
    logic [WORD_W-1:0] r_aux;
    logic [WORD_W-1:0] r_gx;
    logic [WORD_W-1:0] r_gy;
    logic [WORD_W-1:0] r_gz;
    logic [WORD_W-1:0] r_sz;
    logic [WORD_W-1:0] r_pc;

    // table search
    logic [CW-1:0]     r_used;
    logic [CW-1:0]     r_idx;
    logic              r_pend;
    logic [CW-1:0]     r_pend_idx;
    logic              r_hit;
    logic [CW-1:0]     r_hit_slot;
    logic [KEY_W-1:0]  w_rdata;
    logic [AW-1:0]     w_raddr;
    logic              w_in_range;
    logic              w_match;

    // arithmetic stages
    logic [ADDR_W:0]   r_end_src;
    logic [ADDR_W:0]   r_end_dst;
    logic [PROD_W-1:0] r_prod;
    logic [SCALED_W-1:0] r_scaled;

    // decision
    logic              w_src_ok;
    logic              w_dst_ok;
    logic              w_fill_ok;
    logic              w_limits_bad;
    logic              w_grid_bad;
    logic              w_we;
    logic [2:0]        w_status;
    logic [CW-1:0]     w_slot;
    logic [CW+3:0]     w_slot_ext;
    logic [3:0]        w_pat_mask;

    assign w_in_range = (r_idx < r_used);
    assign w_raddr    = w_in_range ? r_idx[AW-1:0] : '0;
    assign w_match    = r_pend && (w_rdata == r_key);

    assign o_sts.key_req     = (r_type == REQ_REGISTER) || (r_type == REQ_DISPATCH);
    assign o_sts.search_done = w_match || (!r_pend && !w_in_range);

    crg_ram #(
        .WIDTH (KEY_W),
        .DEPTH (KERNEL_SLOTS)
    ) u_keys (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_used[AW-1:0]),
        .i_wdata (r_key),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_type <= i_req_type;
            r_key  <= {i_key_exec, i_key_export};
            r_src  <= i_addr_src;
            r_dst  <= i_addr_dst;
            r_len  <= i_byte_len;
            r_aux  <= i_aux_count;
            r_gx   <= i_grid_x;
            r_gy   <= i_grid_y;
            r_gz   <= i_grid_z;
            r_sz   <= i_group_size_z;
            r_pc   <= i_push_const_count;
        end
        if (i_cmd.mul_a) begin
            r_prod    <= {32'd0, r_gx} * {32'd0, r_gy};
            r_end_src <= {1'b0, r_src} + {1'b0, r_len};
            r_end_dst <= {1'b0, r_dst} + {1'b0, r_len};
        end
        if (i_cmd.mul_b) begin
            r_scaled <= {16'd0, r_prod} * {64'd0, r_gz[LIM16_W-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used     <= '0;
            r_idx      <= '0;
            r_pend     <= 1'b0;
            r_pend_idx <= '0;
            r_hit      <= 1'b0;
            r_hit_slot <= '0;
        end else begin
            if (w_we) begin
                r_used <= r_used + 1'b1;
            end
            if (i_cmd.load) begin
                r_idx      <= '0;
                r_pend     <= 1'b0;
                r_hit      <= 1'b0;
                r_hit_slot <= '0;
            end else if (i_cmd.search) begin
                if (w_match) begin
                    r_hit      <= 1'b1;
                    r_hit_slot <= r_pend_idx;
                end
                r_pend     <= w_in_range && !w_match;
                r_pend_idx <= r_idx;
                if (w_in_range && !w_match) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    assign w_src_ok     = (r_end_src <= {1'b0, i_region_size});
    assign w_dst_ok     = (r_end_dst <= {1'b0, i_region_size});
    assign w_pat_mask   = r_aux[3:0] - 4'd1;
    assign w_fill_ok    = ((r_aux == 32'd1) || (r_aux == 32'd2) || (r_aux == 32'd4) ||
                           (r_aux == 32'd8)) && ((r_len[3:0] & w_pat_mask) == 4'd0);
    assign w_limits_bad = (|r_gz[WORD_W-1:LIM16_W]) || (|r_sz[WORD_W-1:LIM16_W]) ||
                          (|r_aux[WORD_W-1:LIM8_W]) || (|r_pc[WORD_W-1:LIM16_W]);
    assign w_grid_bad   = (|r_scaled[SCALED_W-1:WORD_W]) ||
                          (r_scaled[WORD_W-1:0] > i_grid_limit);

    always_comb begin
        w_status = ST_OK;
        w_slot   = '0;
        w_we     = 1'b0;
        case (r_type)
            REQ_REGISTER: begin
                if (r_hit) begin
                    w_slot = r_hit_slot;
                end else if (r_used >= SLOTS) begin
                    w_status = ST_FULL;
                end else begin
                    w_slot = r_used;
                    w_we   = i_cmd.commit;
                end
            end
            REQ_COPY: begin
                if (!(w_src_ok && w_dst_ok)) begin
                    w_status = ST_BOUNDS;
                end
            end
            REQ_FILL: begin
                if (!w_fill_ok) begin
                    w_status = ST_BAD_FILL;
                end else if (!w_dst_ok) begin
                    w_status = ST_BOUNDS;
                end
            end
            REQ_UPDATE, REQ_BIND: begin
                if (!w_dst_ok) begin
                    w_status = ST_BOUNDS;
                end
            end
            REQ_DISPATCH: begin
                if (!r_hit) begin
                    w_status = ST_NO_KERNEL;
                end else begin
                    w_slot = r_hit_slot;
                    if (w_limits_bad) begin
                        w_status = ST_BAD_DISP;
                    end else if (w_grid_bad) begin
                        w_status = ST_BAD_GRID;
                    end
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    assign w_slot_ext = {4'd0, w_slot};

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_status      <= w_status;
            o_kernel_slot <= w_slot_ext[3:0];
        end
    end

`ifndef ASSERT_OFF
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= SLOTS)
        else $error("slot count beyond table depth");

    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |=> (r_used == CW'($past(r_used) + 1'b1)))
        else $error("slot count did not advance on table write");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/crg_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crg_ctrl
// controller: item handshake, search sequencing, result register handshake
// ----------------------------------------------------------------------------
module crg_ctrl import crg_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_cmd      o_cmd,
    input  wire t_sts i_sts
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_MUL    = 2'd2;
    localparam logic [1:0] S_DECIDE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SEARCH;
                end
            end
            S_SEARCH: begin
                o_cmd.mul_a  = 1'b1;
                o_cmd.search = i_sts.key_req;
                if (!i_sts.key_req || i_sts.search_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_b = 1'b1;
                n_state     = S_DECIDE;
            end
            S_DECIDE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef ASSERT_OFF
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (!r_out_valid || !i_out_stall))
        else $error("result overwrote a waiting item");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_SEARCH))
        else $error("accepted item did not start work");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/command_record_guard.sv
`default_nettype none
// ----------------------------------------------------------------------------
// command_record_guard
// checks command records against a shared region and keeps a kernel key table
// ----------------------------------------------------------------------------
// sequence: an item passes the search, multiply and decide states; register
//   and dispatch stay in search while the key table is searched, one table entry
//   read per cycle from the key ram; decide waits while a stalled result is held
// input: a new item is accepted only after the previous result is committed
// reset: synchronous active low, empties the key table and loads register defaults
module command_record_guard import crg_pkg::*; #(
    parameter int unsigned KERNEL_SLOTS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [3:0]        paddr,
    input  wire logic [63:0]       pwdata,
    output logic      [63:0]       prdata,
    output logic                   pready,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [2:0]        i_req_type,
    input  wire logic [WORD_W-1:0] i_key_exec,
    input  wire logic [WORD_W-1:0] i_key_export,
    input  wire logic [ADDR_W-1:0] i_addr_src,
    input  wire logic [ADDR_W-1:0] i_addr_dst,
    input  wire logic [ADDR_W-1:0] i_byte_len,
    input  wire logic [WORD_W-1:0] i_aux_count,
    input  wire logic [WORD_W-1:0] i_grid_x,
    input  wire logic [WORD_W-1:0] i_grid_y,
    input  wire logic [WORD_W-1:0] i_grid_z,
    input  wire logic [WORD_W-1:0] i_group_size_z,
    input  wire logic [WORD_W-1:0] i_push_const_count,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic      [2:0]        o_status,
    output logic      [3:0]        o_kernel_slot
);

    logic [ADDR_W-1:0] r_region_size;
    logic [WORD_W-1:0] r_grid_limit;
    logic              w_wr;
    t_cmd              w_cmd;
    t_sts              w_sts;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_size <= REGION_SIZE_RST;
            r_grid_limit  <= GRID_LIMIT_RST;
        end else if (w_wr) begin
            if (paddr[3] == REG_REGION_SIZE) begin
                r_region_size <= pwdata[ADDR_W-1:0];
            end else begin
                r_grid_limit <= pwdata[WORD_W-1:0];
            end
        end
    end

    assign prdata = (paddr[3] == REG_GRID_LIMIT) ? {32'd0, r_grid_limit}
                                                 : {16'd0, r_region_size};

    crg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    crg_dp #(
        .KERNEL_SLOTS (KERNEL_SLOTS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_region_size      (r_region_size),
        .i_grid_limit       (r_grid_limit),
        .i_req_type         (i_req_type),
        .i_key_exec         (i_key_exec),
        .i_key_export       (i_key_export),
        .i_addr_src         (i_addr_src),
        .i_addr_dst         (i_addr_dst),
        .i_byte_len         (i_byte_len),
        .i_aux_count        (i_aux_count),
        .i_grid_x           (i_grid_x),
        .i_grid_y           (i_grid_y),
        .i_grid_z           (i_grid_z),
        .i_group_size_z     (i_group_size_z),
        .i_push_const_count (i_push_const_count),
        .o_status           (o_status),
        .o_kernel_slot      (o_kernel_slot)
    );

endmodule
`default_nettype wire

FILE: tb/sv/tb_command_record_guard.sv
// ----------------------------------------------------------------------------
// tb_command_record_guard
// self-checking bench for the command record guard: a directed table of
// records, then randomized phases under several region and grid settings,
// with every result checked in order against the table's expected values or an
// in-bench model of the key table, the range checks and the dispatch limits
// ----------------------------------------------------------------------------
module tb_command_record_guard;
    import crg_pkg::*;

    localparam int unsigned KERNEL_SLOTS   = 16;
    localparam int unsigned ABI_LIM16      = 65535;
    localparam int unsigned ABI_LIM8       = 255;
    localparam int unsigned POOL_N         = 24;
    localparam int unsigned PHASES         = 5;
    localparam int unsigned PHASE_ITEMS    = 220;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES  = 40;

    localparam logic [2:0] REQ_RSVD6 = 3'd6;
    localparam logic [2:0] REQ_RSVD7 = 3'd7;

    localparam logic [47:0] ADDR_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] WORD_MAX = 32'hFFFF_FFFF;

    typedef struct {
        logic [2:0]  req;
        logic [31:0] key_exec;
        logic [31:0] key_export;
        logic [47:0] addr_src;
        logic [47:0] addr_dst;
        logic [47:0] byte_len;
        logic [31:0] aux_count;
        logic [31:0] grid_x;
        logic [31:0] grid_y;
        logic [31:0] grid_z;
        logic [31:0] group_size_z;
        logic [31:0] push_const_count;
    } cmd_rec_t;

    typedef struct {
        logic [2:0] status;
        logic [3:0] slot;
    } verdict_t;

    typedef struct {
        bit          is_cfg;
        logic        cfg_idx;
        logic [63:0] cfg_val;
        cmd_rec_t    rec;
        bit          typed;
        verdict_t    want;
    } dir_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_req_type;
    logic [31:0] i_key_exec;
    logic [31:0] i_key_export;
    logic [47:0] i_addr_src;
    logic [47:0] i_addr_dst;
    logic [47:0] i_byte_len;
    logic [31:0] i_aux_count;
    logic [31:0] i_grid_x;
    logic [31:0] i_grid_y;
    logic [31:0] i_grid_z;
    logic [31:0] i_group_size_z;
    logic [31:0] i_push_const_count;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [2:0]  o_status;
    logic [3:0]  o_kernel_slot;

    command_record_guard #(
        .KERNEL_SLOTS(KERNEL_SLOTS)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_req_type         (i_req_type),
        .i_key_exec         (i_key_exec),
        .i_key_export       (i_key_export),
        .i_addr_src         (i_addr_src),
        .i_addr_dst         (i_addr_dst),
        .i_byte_len         (i_byte_len),
        .i_aux_count        (i_aux_count),
        .i_grid_x           (i_grid_x),
        .i_grid_y           (i_grid_y),
        .i_grid_z           (i_grid_z),
        .i_group_size_z     (i_group_size_z),
        .i_push_const_count (i_push_const_count),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_status           (o_status),
        .o_kernel_slot      (o_kernel_slot)
    );

    // model state
    bit [47:0]   m_region;
    bit [31:0]   m_grid_limit;
    bit [63:0]   key_table [KERNEL_SLOTS];
    int unsigned keys_held;

    verdict_t    verdicts_due [$];
    dir_row_t    dir_rows [$];
    bit [63:0]   key_pool [POOL_N];
    int unsigned mismatches;
    int unsigned quiet_cycles;
    int unsigned cnt_req [8];
    int unsigned cnt_status [8];
    int unsigned items_sent;
    bit          send_idle_en;
    bit          rcv_idle_en;
    int unsigned hold_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic bit span_fits(bit [63:0] base, bit [63:0] len);
        bit [63:0] r;
        r = 64'(m_region);
        if (len == 0) return base <= r;
        if (base > r) return 1'b0;
        if (len > r) return 1'b0;
        return base <= r - len;
    endfunction

    function automatic int slot_of(bit [63:0] key);
        for (int i = 0; i < keys_held; i++) begin
            if (key_table[i] == key) return i;
        end
        return -1;
    endfunction

    function automatic verdict_t guard_verdict(cmd_rec_t c);
        verdict_t  v;
        bit [63:0] key;
        bit [63:0] prod;
        int        s;
        v.status = ST_OK;
        v.slot   = 4'd0;
        key      = {c.key_exec, c.key_export};
        case (c.req)
            REQ_REGISTER: begin
                s = slot_of(key);
                if (s >= 0) begin
                    v.slot = 4'(s);
                end else if (keys_held >= KERNEL_SLOTS) begin
                    v.status = ST_FULL;
                end else begin
                    key_table[keys_held] = key;
                    v.slot = 4'(keys_held);
                    keys_held++;
                end
            end
            REQ_COPY: begin
                if (!span_fits(c.addr_src, c.byte_len) || !span_fits(c.addr_dst, c.byte_len))
                    v.status = ST_BOUNDS;
            end
            REQ_FILL: begin
                if (!(c.aux_count inside {32'd1, 32'd2, 32'd4, 32'd8}))
                    v.status = ST_BAD_FILL;
                else if ((64'(c.byte_len) % 64'(c.aux_count)) != 0)
                    v.status = ST_BAD_FILL;
                else if (!span_fits(c.addr_dst, c.byte_len))
                    v.status = ST_BOUNDS;
            end
            REQ_UPDATE, REQ_BIND: begin
                if (!span_fits(c.addr_dst, c.byte_len)) v.status = ST_BOUNDS;
            end
            REQ_DISPATCH: begin
                s = slot_of(key);
                if (s < 0) begin
                    v.status = ST_NO_KERNEL;
                end else begin
                    v.slot = 4'(s);
                    if (c.grid_z > ABI_LIM16 || c.group_size_z > ABI_LIM16 ||
                        c.aux_count > ABI_LIM8 || c.push_const_count > ABI_LIM16) begin
                        v.status = ST_BAD_DISP;
                    end else if (c.grid_z != 0) begin
                        prod = 64'(c.grid_x) * 64'(c.grid_y);
                        if (prod > 64'(m_grid_limit) / 64'(c.grid_z)) v.status = ST_BAD_GRID;
                    end
                end
            end
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [47:0] pick_base();
        bit [63:0] r;
        r = 64'(m_region);
        case ($urandom_range(0, 7))
            0: return 48'd0;
            1: return 48'(r);
            2: return 48'(r + 1);
            3: return 48'(rand64());
            4: return 48'((r > 64) ? r - 64'($urandom_range(0, 64)) : r);
            default: return 48'(rand64() % (r + 1));
        endcase
    endfunction

    function automatic logic [47:0] pick_len(logic [47:0] base);
        bit [63:0] room;
        room = (64'(base) <= 64'(m_region)) ? 64'(m_region) - 64'(base) : 64'd0;
        case ($urandom_range(0, 7))
            0: return 48'd0;
            1: return 48'(room);
            2: return 48'(room + 1);
            3: return 48'(rand64());
            4: return 48'($urandom_range(0, 64));
            default: return 48'(rand64() % (room + 1));
        endcase
    endfunction

    function automatic logic [31:0] pick_pattern();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'd3;
            2: return $urandom;
            3: return 32'd16;
            default: return 32'd1 << $urandom_range(0, 3);
        endcase
    endfunction

    function automatic logic [31:0] pick_abi(int unsigned lim);
        case ($urandom_range(0, 9))
            0: return 32'(lim);
            1: return 32'(lim + 1);
            2: return $urandom;
            default: return 32'($urandom_range(0, lim));
        endcase
    endfunction

    function automatic cmd_rec_t make_rec();
        cmd_rec_t    c;
        int unsigned pick;
        bit [63:0]   per_z;
        c.key_exec         = $urandom;
        c.key_export       = $urandom;
        c.addr_src         = 48'(rand64());
        c.addr_dst         = 48'(rand64());
        c.byte_len         = 48'(rand64());
        c.aux_count        = $urandom;
        c.grid_x           = $urandom;
        c.grid_y           = $urandom;
        c.grid_z           = $urandom;
        c.group_size_z     = $urandom;
        c.push_const_count = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 12) c.req = REQ_REGISTER;
        else if (pick < 27) c.req = REQ_COPY;
        else if (pick < 42) c.req = REQ_FILL;
        else if (pick < 54) c.req = REQ_UPDATE;
        else if (pick < 80) c.req = REQ_DISPATCH;
        else if (pick < 97) c.req = REQ_BIND;
        else c.req = pick[0] ? REQ_RSVD6 : REQ_RSVD7;
        case (c.req)
            REQ_REGISTER: begin
                if ($urandom_range(0, 9) != 0)
                    {c.key_exec, c.key_export} = key_pool[$urandom_range(0, POOL_N - 1)];
            end
            REQ_COPY: begin
                c.addr_src = pick_base();
                c.addr_dst = pick_base();
                c.byte_len = $urandom_range(0, 1) ? pick_len(c.addr_src) : pick_len(c.addr_dst);
            end
            REQ_FILL: begin
                c.addr_dst  = pick_base();
                c.byte_len  = pick_len(c.addr_dst);
                c.aux_count = pick_pattern();
                if (c.aux_count inside {32'd1, 32'd2, 32'd4, 32'd8} && $urandom_range(0, 3) != 0)
                    c.byte_len = c.byte_len & ~48'(c.aux_count - 1);
            end
            REQ_UPDATE, REQ_BIND: begin
                c.addr_dst = pick_base();
                c.byte_len = pick_len(c.addr_dst);
            end
            REQ_DISPATCH: begin
                if ($urandom_range(0, 99) < 85)
                    {c.key_exec, c.key_export} = key_pool[$urandom_range(0, POOL_N - 1)];
                c.aux_count        = pick_abi(ABI_LIM8);
                c.group_size_z     = pick_abi(ABI_LIM16);
                c.push_const_count = pick_abi(ABI_LIM16);
                c.grid_z = $urandom_range(0, 1) ? 32'($urandom_range(0, 16)) : pick_abi(ABI_LIM16);
                case ($urandom_range(0, 4))
                    0: ;
                    1: begin
                        c.grid_x = $urandom_range(0, 64);
                        c.grid_y = $urandom_range(0, 64);
                    end
                    2: begin
                        if (c.grid_z != 0 && c.grid_z <= ABI_LIM16) begin
                            per_z    = 64'(m_grid_limit) / 64'(c.grid_z);
                            c.grid_x = $urandom_range(1, 1024);
                            c.grid_y = 32'(per_z / 64'(c.grid_x)) + $urandom_range(0, 1);
                        end
                    end
                    default: begin
                        c.grid_x = $urandom_range(0, 4096);
                        c.grid_y = $urandom_range(0, 4096);
                    end
                endcase
            end
            default: ;
        endcase
        return c;
    endfunction

    function automatic cmd_rec_t mk_rec(logic [2:0] req, logic [31:0] kx, logic [31:0] ke,
                                        logic [47:0] src, logic [47:0] dst, logic [47:0] len,
                                        logic [31:0] aux, logic [31:0] gx, logic [31:0] gy,
                                        logic [31:0] gz, logic [31:0] sz, logic [31:0] pc);
        cmd_rec_t c;
        c.req = req;
        c.key_exec = kx;
        c.key_export = ke;
        c.addr_src = src;
        c.addr_dst = dst;
        c.byte_len = len;
        c.aux_count = aux;
        c.grid_x = gx;
        c.grid_y = gy;
        c.grid_z = gz;
        c.group_size_z = sz;
        c.push_const_count = pc;
        return c;
    endfunction

    task automatic add_rec(cmd_rec_t c, bit typed, logic [2:0] st, logic [3:0] slot);
        dir_row_t r;
        r.is_cfg  = 1'b0;
        r.cfg_idx = 1'b0;
        r.cfg_val = '0;
        r.rec     = c;
        r.typed   = typed;
        r.want    = '{st, slot};
        dir_rows.push_back(r);
    endtask

    task automatic add_cfg(logic idx, logic [63:0] val);
        dir_row_t r;
        r.is_cfg  = 1'b1;
        r.cfg_idx = idx;
        r.cfg_val = val;
        r.rec     = mk_rec(REQ_COPY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        r.typed   = 1'b0;
        r.want    = '{ST_OK, 4'd0};
        dir_rows.push_back(r);
    endtask

    // present one item, predict its result once it is taken
    task automatic send_item(cmd_rec_t c, bit typed, verdict_t want);
        verdict_t v;
        @(negedge i_clk);
        while (send_idle_en && $urandom_range(0, 99) < 16) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_req_type         <= c.req;
        i_key_exec         <= c.key_exec;
        i_key_export       <= c.key_export;
        i_addr_src         <= c.addr_src;
        i_addr_dst         <= c.addr_dst;
        i_byte_len         <= c.byte_len;
        i_aux_count        <= c.aux_count;
        i_grid_x           <= c.grid_x;
        i_grid_y           <= c.grid_y;
        i_grid_z           <= c.grid_z;
        i_group_size_z     <= c.group_size_z;
        i_push_const_count <= c.push_const_count;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        v = guard_verdict(c);
        verdicts_due.push_back(typed ? want : v);
        cnt_req[c.req]++;
        items_sent++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [63:0] val);
        logic [63:0] mask;
        mask = (idx == REG_REGION_SIZE) ? 64'(ADDR_MAX) : 64'(WORD_MAX);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (idx == REG_REGION_SIZE) m_region = val[47:0];
        else m_grid_limit = val[31:0];
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if ((prdata & mask) !== (val & mask)) begin
            $error("%s readback mismatch: expected %0h, got %0h",
                   (idx == REG_REGION_SIZE) ? "region_size" : "grid_limit",
                   val & mask, prdata & mask);
            mismatches++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // result side: random stall, plus one long hold-off on request
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (rcv_idle_en) begin
                i_out_stall <= ($urandom_range(0, 99) < 16);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        verdict_t want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (verdicts_due.size() == 0) begin
                $error("result with no item waiting: status %0d, kernel_slot %0d",
                       o_status, o_kernel_slot);
                mismatches++;
            end else begin
                want = verdicts_due.pop_front();
                if (o_status !== want.status) begin
                    $error("status mismatch: expected %0d, got %0d", want.status, o_status);
                    mismatches++;
                end
                if (o_kernel_slot !== want.slot) begin
                    $error("kernel_slot mismatch: expected %0d, got %0d",
                           want.slot, o_kernel_slot);
                    mismatches++;
                end
                cnt_status[o_status]++;
            end
        end
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        logic [63:0] reg_val;
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        i_in_valid         = 1'b0;
        i_req_type         = '0;
        i_key_exec         = '0;
        i_key_export       = '0;
        i_addr_src         = '0;
        i_addr_dst         = '0;
        i_byte_len         = '0;
        i_aux_count        = '0;
        i_grid_x           = '0;
        i_grid_y           = '0;
        i_grid_z           = '0;
        i_group_size_z     = '0;
        i_push_const_count = '0;
        m_region           = REGION_SIZE_RST;
        m_grid_limit       = GRID_LIMIT_RST;
        keys_held          = 0;
        mismatches         = 0;
        quiet_cycles       = 0;
        items_sent         = 0;
        hold_left          = 0;
        send_idle_en       = 1'b1;
        rcv_idle_en        = 1'b1;
        foreach (cnt_req[i]) cnt_req[i] = 0;
        foreach (cnt_status[i]) cnt_status[i] = 0;

        key_pool[0] = 64'd0;
        key_pool[1] = {WORD_MAX, WORD_MAX};
        key_pool[2] = {WORD_MAX, 32'd0};
        key_pool[3] = {32'd0, WORD_MAX};
        for (int i = 4; i < POOL_N; i++) key_pool[i] = rand64();

        // reset defaults: empty region, default grid limit
        add_rec(mk_rec(REQ_COPY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, ST_OK, 0);
        add_rec(mk_rec(REQ_UPDATE, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0), 1, ST_BOUNDS, 0);
        add_rec(mk_rec(REQ_BIND, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0), 1, ST_BOUNDS, 0);
        add_rec(mk_rec(REQ_DISPATCH, 0, 0, 0, 0, 0, 0, 1, 1, 1, 0, 0), 1, ST_NO_KERNEL, 0);
        add_rec(mk_rec(REQ_REGISTER, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, ST_OK, 0);
        add_rec(mk_rec(REQ_REGISTER, WORD_MAX, WORD_MAX, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                1, ST_OK, 1);
        add_rec(mk_rec(REQ_REGISTER, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, ST_OK, 0);
        add_rec(mk_rec(REQ_FILL, 0, 0, 0, 0, 6, 3, 0, 0, 0, 0, 0), 1, ST_BAD_FILL, 0);
        add_rec(mk_rec(REQ_RSVD7, WORD_MAX, WORD_MAX, ADDR_MAX, ADDR_MAX, ADDR_MAX, WORD_MAX,
                       WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX), 1, ST_OK, 0);
        add_rec(mk_rec(REQ_RSVD6, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, ST_OK, 0);
        // widest region and grid limit
        add_cfg(REG_REGION_SIZE, 64'(ADDR_MAX));
        add_cfg(REG_GRID_LIMIT, 64'(WORD_MAX));
        add_rec(mk_rec(REQ_COPY, 0, 0, 0, 0, ADDR_MAX, 0, 0, 0, 0, 0, 0), 0, ST_OK, 0);
        add_rec(mk_rec(REQ_COPY, 0, 0, ADDR_MAX, 0, 1, 0, 0, 0, 0, 0, 0), 0, ST_OK, 0);
        add_rec(mk_rec(REQ_FILL, 0, 0, 0, ADDR_MAX - 15, 16, 8, 0, 0, 0, 0, 0), 0, ST_OK, 0);
        add_rec(mk_rec(REQ_FILL, 0, 0, 0, 0, 6, 4, 0, 0, 0, 0, 0), 1, ST_BAD_FILL, 0);
        add_rec(mk_rec(REQ_FILL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, ST_BAD_FILL, 0);
        add_rec(mk_rec(REQ_DISPATCH, WORD_MAX, WORD_MAX, 0, 0, 0, 0, 1, 1, 65536, 0, 0),
                1, ST_BAD_DISP, 1);
        add_rec(mk_rec(REQ_DISPATCH, WORD_MAX, WORD_MAX, 0, 0, 0, 256, 1, 1, 1, 0, 0),
                1, ST_BAD_DISP, 1);
        add_rec(mk_rec(REQ_DISPATCH, WORD_MAX, WORD_MAX, 0, 0, 0, 0, 1, 1, 1, 0, 65536),
                1, ST_BAD_DISP, 1);
        add_rec(mk_rec(REQ_DISPATCH, WORD_MAX, WORD_MAX, 0, 0, 0, 255, 1, 1, 65535, 65535,
                       65535), 0, ST_OK, 0);
        add_rec(mk_rec(REQ_DISPATCH, WORD_MAX, WORD_MAX, 0, 0, 0, 0, WORD_MAX, WORD_MAX,
                       65535, 0, 0), 0, ST_OK, 0);
        add_rec(mk_rec(REQ_DISPATCH, 0, 0, 0, 0, 0, 0, WORD_MAX, WORD_MAX, 0, 0, 0),
                0, ST_OK, 0);
        // small region, zero grid limit
        add_cfg(REG_REGION_SIZE, 64'd4096);
        add_cfg(REG_GRID_LIMIT, 64'd0);
        add_rec(mk_rec(REQ_DISPATCH, 0, 0, 0, 0, 0, 0, 1, 1, 1, 0, 0), 0, ST_OK, 0);
        add_rec(mk_rec(REQ_DISPATCH, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0), 0, ST_OK, 0);
        add_rec(mk_rec(REQ_UPDATE, 0, 0, 0, 4096, 0, 0, 0, 0, 0, 0, 0), 0, ST_OK, 0);
        add_rec(mk_rec(REQ_BIND, 0, 0, 0, 4000, 97, 0, 0, 0, 0, 0, 0), 0, ST_OK, 0);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                drain_results();
                write_reg(dir_rows[i].cfg_idx, dir_rows[i].cfg_val);
            end else begin
                send_item(dir_rows[i].rec, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results();
            case (ph)
                0: reg_val = 64'(ADDR_MAX);
                1: reg_val = 64'd0;
                2: reg_val = 64'($urandom_range(1, 65536));
                3: reg_val = 64'(rand64() & 64'(ADDR_MAX));
                default: reg_val = 64'd4096;
            endcase
            write_reg(REG_REGION_SIZE, reg_val);
            case (ph)
                0: reg_val = 64'(WORD_MAX);
                1: reg_val = 64'd0;
                2: reg_val = 64'($urandom_range(1, 100000));
                3: reg_val = 64'($urandom);
                default: reg_val = 64'(GRID_LIMIT_RST);
            endcase
            write_reg(REG_GRID_LIMIT, reg_val);
            // first phase runs with no idling on either side
            send_idle_en = (ph != 0);
            rcv_idle_en  = (ph != 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_item(make_rec(), 1'b0, '{ST_OK, 4'd0});
                if (ph == 2 && n == 40) hold_left = HOLD_CYCLES;
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d items: register %0d, copy %0d, fill %0d, update %0d, ",
                 items_sent, cnt_req[REQ_REGISTER], cnt_req[REQ_COPY], cnt_req[REQ_FILL],
                 cnt_req[REQ_UPDATE], "dispatch %0d, binding %0d, reserved %0d",
                 cnt_req[REQ_DISPATCH], cnt_req[REQ_BIND],
                 cnt_req[REQ_RSVD6] + cnt_req[REQ_RSVD7]);
        $display("results ok %0d, bounds %0d, bad fill %0d, no kernel %0d, ",
                 cnt_status[ST_OK], cnt_status[ST_BOUNDS], cnt_status[ST_BAD_FILL],
                 cnt_status[ST_NO_KERNEL], "bad dispatch %0d, bad grid %0d, table full %0d",
                 cnt_status[ST_BAD_DISP], cnt_status[ST_BAD_GRID], cnt_status[ST_FULL]);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/crg_pkg.sv
hw/rtl/crg_ram.sv
hw/rtl/crg_dp.sv
hw/rtl/crg_ctrl.sv
hw/rtl/command_record_guard.sv
tb/sv/tb_command_record_guard.sv
